@@ hdl/obci_pkg.sv @@
// Package for the octree box cell index unit: sizes, register indexes
// and the level base-offset function. No dependencies.
package obci_pkg;

    localparam int LEVELS    = 5;
    localparam int LVL_W     = $clog2(LEVELS + 1);
    localparam int COORD_W   = LEVELS;
    localparam int CODE_W    = 3 * LEVELS;
    localparam int IDX_W     = 3 * LEVELS + 1;
    localparam int SHAMT_W   = $clog2(CODE_W + 1);
    localparam int CFG_IDX_W = 3;

    localparam int IN_W   = 6 * 32 + 16;
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W  = 16 + 3 + 16;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BOUNDS_X = 3'd0;
    localparam t_cfg_idx CFG_BOUNDS_Y = 3'd1;
    localparam t_cfg_idx CFG_BOUNDS_Z = 3'd2;
    localparam t_cfg_idx CFG_SCALE_X  = 3'd3;
    localparam t_cfg_idx CFG_SCALE_Y  = 3'd4;
    localparam t_cfg_idx CFG_SCALE_Z  = 3'd5;

    localparam logic [32:0] SCALE_ONE = 33'h1_0000_0000;
    localparam logic [32:0] COORD_MAX = 33'((1 << LEVELS) - 1);

    // (8^lvl - 1) / 7
    function automatic logic [IDX_W-1:0] base_of(input logic [LVL_W-1:0] lvl);
        logic [IDX_W-1:0] b;
        b = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (LVL_W'(i) < lvl) begin
                b = {b[IDX_W-4:0], 3'b001};
            end
        end
        return b;
    endfunction

endpackage

@@ hdl/octree_box_cell_index_unit.sv @@
// Octree box cell index unit: clamp, quantize, Morton code and linear index.
// Depends on obci_pkg.
// Each box passes through the stage 1 to 4 registers and the output register.
// Throughput: one box per cycle; the whole pipeline stalls while the output
// register holds an untaken result (one 32x32 multiplier per corner and axis).
// Reset (i_rst_n low, synchronous) empties the pipeline, clears bounds to 0
// and sets every scale to 1.0.
module octree_box_cell_index_unit
    import obci_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, item_tag
    input  logic [IN_TW-1:0]     s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // cell_index, cell_level, tag_out, zero pad
    output logic [OUT_TW-1:0]    m_axis_tdata,
    // accepted
    output logic                 m_axis_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [63:0]          i_cfg_data
);

    logic [63:0] r_bounds [3];
    logic [32:0] r_scale  [3];

    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage 1: clamped corners
    logic signed [31:0] r_s1_lo [3];
    logic signed [31:0] r_s1_hi [3];
    logic [15:0]        r_s1_tag;
    // stage 2: offsets and empty test
    logic [31:0] r_s2_olo [3];
    logic [31:0] r_s2_ohi [3];
    logic        r_s2_ok;
    logic [15:0] r_s2_tag;
    // stage 3: products
    logic [31:0] r_s3_plo [3];
    logic [31:0] r_s3_phi [3];
    logic [31:0] r_s3_olo [3];
    logic [31:0] r_s3_ohi [3];
    logic        r_s3_ok;
    logic [15:0] r_s3_tag;
    // stage 4: Morton code and shift
    logic [CODE_W-1:0] r_s4_cmin;
    logic [LVL_W-1:0]  r_s4_shift;
    logic              r_s4_ok;
    logic [15:0]       r_s4_tag;
    // output register
    logic [15:0] r_idx;
    logic [2:0]  r_level;
    logic [15:0] r_tag;
    logic        r_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_bounds[a] <= '0;
                r_scale[a]  <= SCALE_ONE;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_BOUNDS_X: r_bounds[0] <= i_cfg_data;
                CFG_BOUNDS_Y: r_bounds[1] <= i_cfg_data;
                CFG_BOUNDS_Z: r_bounds[2] <= i_cfg_data;
                CFG_SCALE_X:  r_scale[0]  <= i_cfg_data[32:0];
                CFG_SCALE_Y:  r_scale[1]  <= i_cfg_data[32:0];
                CFG_SCALE_Z:  r_scale[2]  <= i_cfg_data[32:0];
                default: ;
            endcase
        end
    end

    assign en            = !r_v5 || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1
    logic signed [31:0] n_s1_lo [3];
    logic signed [31:0] n_s1_hi [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [31:0] in_lo, in_hi, rlo, rhi;
            in_lo = s_axis_tdata[32*a +: 32];
            in_hi = s_axis_tdata[96 + 32*a +: 32];
            rlo   = r_bounds[a][31:0];
            rhi   = r_bounds[a][63:32];
            n_s1_lo[a] = (in_lo <= rlo) ? rlo : in_lo;
            n_s1_hi[a] = (in_hi >= rhi) ? rhi : in_hi;
        end
    end

    // stage 2
    logic [31:0] n_s2_olo [3];
    logic [31:0] n_s2_ohi [3];
    logic        n_s2_ok;

    always_comb begin
        n_s2_ok = 1'b1;
        for (int a = 0; a < 3; a++) begin
            logic signed [32:0] rlo;
            logic signed [32:0] dlo, dhi;
            rlo = 33'(signed'(r_bounds[a][31:0]));
            dlo = 33'(r_s1_lo[a]) - rlo;
            dhi = 33'(r_s1_hi[a]) - rlo;
            n_s2_olo[a] = dlo[31:0];
            n_s2_ohi[a] = dhi[31:0];
            if (r_s1_lo[a] >= r_s1_hi[a]) begin
                n_s2_ok = 1'b0;
            end
        end
    end

    // stage 3
    logic [63:0] n_s3_plo [3];
    logic [63:0] n_s3_phi [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_s3_plo[a] = 64'(r_s2_olo[a]) * 64'(r_scale[a][31:0]);
            n_s3_phi[a] = 64'(r_s2_ohi[a]) * 64'(r_scale[a][31:0]);
        end
    end

    // stage 4
    logic [COORD_W-1:0] n_s4_clo [3];
    logic [COORD_W-1:0] n_s4_chi [3];
    logic [CODE_W-1:0]  n_s4_cmin, n_s4_cmax, n_s4_diff;
    logic [LVL_W-1:0]   n_s4_shift;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic [32:0] qlo, qhi;
            qlo = 33'(r_s3_plo[a]) + (r_scale[a][32] ? 33'(r_s3_olo[a]) : 33'd0);
            qhi = 33'(r_s3_phi[a]) + (r_scale[a][32] ? 33'(r_s3_ohi[a]) : 33'd0);
            n_s4_clo[a] = (qlo > COORD_MAX) ? COORD_MAX[COORD_W-1:0] : qlo[COORD_W-1:0];
            n_s4_chi[a] = (qhi > COORD_MAX) ? COORD_MAX[COORD_W-1:0] : qhi[COORD_W-1:0];
        end
        for (int b = 0; b < LEVELS; b++) begin
            for (int a = 0; a < 3; a++) begin
                n_s4_cmin[3*b + a] = n_s4_clo[a][b];
                n_s4_cmax[3*b + a] = n_s4_chi[a][b];
            end
        end
        n_s4_diff  = n_s4_cmin ^ n_s4_cmax;
        n_s4_shift = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (n_s4_diff[3*i +: 3] != 3'b000) begin
                n_s4_shift = LVL_W'(i + 1);
            end
        end
    end

    // stage 5
    logic [LVL_W-1:0]   n_s5_level;
    logic [SHAMT_W-1:0] n_s5_shamt;
    logic [IDX_W-1:0]   n_s5_idx;

    always_comb begin
        n_s5_level = LVL_W'(LEVELS) - r_s4_shift;
        n_s5_shamt = SHAMT_W'(r_s4_shift) * SHAMT_W'(3);
        n_s5_idx   = IDX_W'(r_s4_cmin >> n_s5_shamt) + base_of(n_s5_level);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_s1_lo[a]  <= n_s1_lo[a];
                r_s1_hi[a]  <= n_s1_hi[a];
                r_s2_olo[a] <= n_s2_olo[a];
                r_s2_ohi[a] <= n_s2_ohi[a];
                r_s3_plo[a] <= n_s3_plo[a][63:32];
                r_s3_phi[a] <= n_s3_phi[a][63:32];
                r_s3_olo[a] <= r_s2_olo[a];
                r_s3_ohi[a] <= r_s2_ohi[a];
            end
            r_s1_tag   <= s_axis_tdata[207:192];
            r_s2_ok    <= n_s2_ok;
            r_s2_tag   <= r_s1_tag;
            r_s3_ok    <= r_s2_ok;
            r_s3_tag   <= r_s2_tag;
            r_s4_cmin  <= n_s4_cmin;
            r_s4_shift <= n_s4_shift;
            r_s4_ok    <= r_s3_ok;
            r_s4_tag   <= r_s3_tag;
            r_acc      <= r_s4_ok;
            r_tag      <= r_s4_tag;
            r_idx      <= r_s4_ok ? 16'(n_s5_idx) : 16'd0;
            r_level    <= r_s4_ok ? 3'(n_s5_level) : 3'd0;
        end
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tuser  = r_acc;
    assign m_axis_tdata  = {(OUT_TW - OUT_W)'(0), r_tag, r_level, r_idx};

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[18:0] == 19'd0)
        else $error("rejected box with non-zero index or level");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && en |=> r_v5)
        else $error("pipeline lost a transaction at the output stage");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v4) && $stable(r_s4_cmin) && $stable(r_s4_tag))
        else $error("stage 4 changed during stall");

endmodule

@@ test/octree_box_cell_index_unit_tb.sv @@
// Self-checking testbench for octree_box_cell_index_unit: boxes are streamed in,
// each result is checked against a cell-index predictor held in a scoreboard class.
// Depends on obci_pkg and the unit itself.
`timescale 1ns / 1ps

module octree_box_cell_index_unit_tb;
    import obci_pkg::*;

    localparam int     CYCLE_LIMIT    = 1_000_000;
    localparam int     RX_HOLD_CYCLES = 150;
    localparam int     DRAIN_CYCLES   = 10;
    localparam int     PHASES         = 12;
    localparam int     PHASE_BOXES    = 161;
    localparam longint CMIN           = -64'sd2147483648;
    localparam longint CMAX           = 64'sd2147483647;

    typedef enum int {
        ROOT_SPREAD,
        ROOT_UNIT,
        ROOT_FULL,
        ROOT_ODD_SCALE,
        ROOT_EDGE_SCALE,
        ROOT_INVERTED
    } t_root_kind;

    // same layout as s_axis_tdata, lowest field last
    typedef struct packed {
        logic [15:0]      tag;
        logic [2:0][31:0] hi;
        logic [2:0][31:0] lo;
    } t_box;

    typedef struct packed {
        logic        accepted;
        logic [15:0] tag;
        logic [2:0]  level;
        logic [15:0] index;
    } t_cell;

    class t_cell_index_board;
        logic [63:0] bounds [3];
        logic [32:0] scale [3];
        t_cell       awaited[$];
        int          n_bad;
        int          n_boxes;
        int          n_hits;
        int          per_level [8];

        function new();
            for (int a = 0; a < 3; a++) begin
                bounds[a] = '0;
                scale[a]  = SCALE_ONE;
            end
            n_bad   = 0;
            n_boxes = 0;
            n_hits  = 0;
            for (int l = 0; l < 8; l++) per_level[l] = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [63:0] val);
            if (idx <= CFG_BOUNDS_Z)
                bounds[idx] = val;
            else if (idx <= CFG_SCALE_Z)
                scale[idx - CFG_SCALE_X] = val[32:0];
        endfunction

        // integer part of off * scale (Q1.32), saturated at the finest coordinate
        function logic [COORD_W-1:0] quantize_offset(logic [31:0] off, logic [32:0] s);
            logic [64:0] p;
            p = {33'b0, off} * {32'b0, s};
            if (p[64:32] > COORD_MAX) return COORD_MAX[COORD_W-1:0];
            return p[32 +: COORD_W];
        endfunction

        function t_cell cell_of(t_box b);
            t_cell               c;
            logic signed [31:0]  rlo, rhi, lo, hi;
            logic [COORD_W-1:0]  qlo [3];
            logic [COORD_W-1:0]  qhi [3];
            logic [CODE_W-1:0]   clo, chi, diff;
            logic [IDX_W-1:0]    base, idx;
            int                  a, i, shift, lvl;
            c = '0;
            c.tag = b.tag;
            for (a = 0; a < 3; a++) begin
                rlo = bounds[a][31:0];
                rhi = bounds[a][63:32];
                lo  = b.lo[a];
                hi  = b.hi[a];
                if (lo <= rlo) lo = rlo;
                if (hi >= rhi) hi = rhi;
                if (lo >= hi) return c;
                qlo[a] = quantize_offset(lo - rlo, scale[a]);
                qhi[a] = quantize_offset(hi - rlo, scale[a]);
            end
            // Morton order: x, y, z from the low bit of each group
            for (i = 0; i < LEVELS; i++) begin
                for (a = 0; a < 3; a++) begin
                    clo[3*i + a] = qlo[a][i];
                    chi[3*i + a] = qhi[a][i];
                end
            end
            diff  = clo ^ chi;
            shift = 0;
            for (i = 0; i < LEVELS; i++)
                if (diff[3*i +: 3] != '0) shift = i + 1;
            lvl  = LEVELS - shift;
            base = '0;
            for (i = 0; i < lvl; i++) base = base * 8 + 1;
            idx = IDX_W'(clo >> (3 * shift)) + base;
            c.accepted = 1'b1;
            c.index    = idx[15:0];
            c.level    = lvl[2:0];
            return c;
        endfunction

        function void note_box(t_box b);
            awaited.push_back(cell_of(b));
            n_boxes++;
        endfunction

        function void compare_field(string fld, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                n_bad++;
                $display("%0t: %s expected %0d got %0d", $time, fld, want, got);
            end
        endfunction

        function void check_result(logic [OUT_TW-1:0] d, logic u);
            t_cell want, got;
            got.accepted = u;
            got.index    = d[15:0];
            got.level    = d[18:16];
            got.tag      = d[34:19];
            if (awaited.size() == 0) begin
                n_bad++;
                $display("%0t: unexpected result, expected none got tuser=%0b tdata=%h",
                         $time, u, d);
                return;
            end
            want = awaited.pop_front();
            compare_field("accepted", 16'(want.accepted), 16'(got.accepted));
            compare_field("cell_index", want.index, got.index);
            compare_field("cell_level", 16'(want.level), 16'(got.level));
            compare_field("tag_out", want.tag, got.tag);
            if (want.accepted) begin
                n_hits++;
                per_level[want.level]++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_TW-1:0]     s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_TW-1:0]    m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [63:0]          i_cfg_data;

    t_cell_index_board board = new();
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    bit                rx_hold_req = 1'b0;
    int                cycles = 0;

    octree_box_cell_index_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, board.awaited.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // transaction monitors, sampled on the pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note_box(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint rand_below(longint n);
        return longint'({$urandom, $urandom} % n);
    endfunction

    function automatic logic [31:0] to_coord(longint v);
        if (v < CMIN) v = CMIN;
        if (v > CMAX) v = CMAX;
        return v[31:0];
    endfunction

    function automatic t_box mk_box(longint lx, longint ly, longint lz,
                                    longint hx, longint hy, longint hz,
                                    logic [15:0] tag);
        t_box b;
        b.lo  = {to_coord(lz), to_coord(ly), to_coord(lx)};
        b.hi  = {to_coord(hz), to_coord(hy), to_coord(hx)};
        b.tag = tag;
        return b;
    endfunction

    // mostly boxes around the current root, some noise, inverted and flat ones
    function automatic t_box random_box();
        t_box   b;
        longint rmin, rmax, span, lo, sz;
        int     a, r;
        r     = $urandom_range(0, 99);
        b.tag = 16'($urandom);
        for (a = 0; a < 3; a++) begin
            rmin = longint'($signed(board.bounds[a][31:0]));
            rmax = longint'($signed(board.bounds[a][63:32]));
            span = rmax - rmin;
            if (span < 8) span = 64;
            if (r < 8) begin
                b.lo[a] = $urandom;
                b.hi[a] = $urandom;
            end else begin
                lo = rmin - span / 16 + rand_below(span + span / 8 + 1);
                sz = rand_below((span >> $urandom_range(0, 8)) + 1);
                if (r < 14)
                    sz = -sz;
                else if (r < 17)
                    sz = 0;
                b.lo[a] = to_coord(lo);
                b.hi[a] = to_coord(lo + sz);
            end
        end
        return b;
    endfunction

    task automatic send_box(t_box b);
        if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic set_axis(int a, longint rmin, longint rmax, logic [32:0] s);
        write_reg(t_cfg_idx'(CFG_BOUNDS_X + a), {rmax[31:0], rmin[31:0]});
        write_reg(t_cfg_idx'(CFG_SCALE_X + a), 64'(s));
    endtask

    task automatic set_phase(t_root_kind kind);
        longint      rmin, span;
        logic [32:0] s;
        int          a, odd;
        odd = $urandom_range(0, 2);
        for (a = 0; a < 3; a++) begin
            rmin = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
            span = $urandom_range(32, 1 << 20);
            s    = 33'((64'd32 << 32) / span);
            case (kind)
                ROOT_UNIT: begin
                    span = 32;
                    s    = SCALE_ONE;
                end
                ROOT_FULL: begin
                    rmin = CMIN;
                    span = CMAX - CMIN;
                    s    = 33'd32;
                end
                ROOT_ODD_SCALE: begin
                    s = (a == odd) ? SCALE_ONE : 33'($urandom);
                end
                ROOT_EDGE_SCALE: begin
                    span = 64;
                    s = (a == odd) ? 33'd0 : (a == (odd + 1) % 3) ? 33'h1_8000_0000 : SCALE_ONE;
                end
                ROOT_INVERTED: begin
                    if (a == odd) span = -longint'($urandom_range(1, 1000));
                end
                default: ;
            endcase
            set_axis(a, rmin, rmin + span, s);
        end
    endtask

    task automatic park_and_drain();
        s_axis_tvalid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : result_sink
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int a, ph, n;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_addr    <= CFG_BOUNDS_X;
        i_cfg_data    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset every root is empty
        send_box(mk_box(-5, -5, -5, 5, 5, 5, 16'h1234));
        send_box(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 16'hA5A5));
        park_and_drain();

        // root [0,32) with unit cells
        for (a = 0; a < 3; a++) set_axis(a, 0, 32, SCALE_ONE);
        send_box(mk_box(0, 0, 0, 32, 32, 32, 16'h0000));
        send_box(mk_box(0, 0, 0, 1, 1, 1, 16'hFFFF));
        send_box(mk_box(3, 9, 17, 3, 9, 17, 16'h0001));
        send_box(mk_box(10, 10, 10, 3, 3, 3, 16'h8000));
        send_box(mk_box(-100, -100, -100, -50, -50, -50, 16'h0002));
        send_box(mk_box(40, 40, 40, 100, 100, 100, 16'h0003));
        send_box(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 16'h7FFF));
        send_box(mk_box(5, 0, 0, 5, 32, 32, 16'h0004));
        send_box(mk_box(30, 30, 30, 31, 31, 31, 16'h0005));
        park_and_drain();

        // full signed range, 2^27 per finest cell
        for (a = 0; a < 3; a++) set_axis(a, CMIN, CMAX, 33'd32);
        send_box(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 16'h0100));
        send_box(mk_box(0, 0, 0, 1, 1, 1, 16'h0101));
        send_box(mk_box(CMIN, CMIN, CMIN, CMIN + 1, CMIN + 1, CMIN + 1, 16'h0102));
        send_box(mk_box(CMAX - 1, CMAX - 1, CMAX - 1, CMAX, CMAX, CMAX, 16'h0103));
        send_box(mk_box(-1, -1, -1, 0, 0, 0, 16'h0104));
        send_box(mk_box(-1, 1000, 1 << 28, 0, 2000, (1 << 28) + 5, 16'h0105));
        park_and_drain();

        // zero scale on x, above unity on y
        set_axis(0, 0, 64, 33'd0);
        set_axis(1, 0, 64, 33'h1_8000_0000);
        set_axis(2, 0, 64, SCALE_ONE);
        send_box(mk_box(0, 0, 0, 64, 64, 64, 16'h0200));
        send_box(mk_box(10, 10, 10, 11, 11, 11, 16'h0201));
        park_and_drain();

        for (ph = 0; ph < PHASES; ph++) begin
            set_phase(t_root_kind'(ph % 6));
            case ((ph + ph / 6) % 3)
                0: tx_idle_pct = 0;
                1: tx_idle_pct = 15;
                default: tx_idle_pct = 50;
            endcase
            rx_idle_pct = tx_idle_pct;
            if (ph == 2) begin
                // sink holds off while the source keeps offering
                tx_idle_pct = 0;
                rx_idle_pct = 20;
                rx_hold_req = 1'b1;
            end
            for (n = 0; n < PHASE_BOXES; n++) send_box(random_box());
            park_and_drain();
        end

        $display("%0d boxes over %0d root setups: %0d hit the root, %0d rejected",
                 board.n_boxes, PHASES + 4, board.n_hits, board.n_boxes - board.n_hits);
        $display("hits per level 0..5: %0d %0d %0d %0d %0d %0d",
                 board.per_level[0], board.per_level[1], board.per_level[2],
                 board.per_level[3], board.per_level[4], board.per_level[5]);
        if (board.n_bad == 0 && board.awaited.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
